// ===== rtl/core/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

    // built depth of the store
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // counts 0..ENTRIES
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    // input kind codes
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // one queued operation after decode
    typedef struct packed {
        logic                    is_put;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_item;

    // one result word
    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/lkv_if.sv =====
`default_nettype none

interface lkv_in_if import lkv_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] put_value;

    modport source (output valid, output kind, output lookup_key, output put_value,
                    input ready);
    modport sink   (input valid, input kind, input lookup_key, input put_value,
                    output ready);
endinterface

interface lkv_out_if import lkv_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;

    modport source (output valid, output hit, output read_value, output evicted,
                    input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lkv_front.sv =====
`default_nettype none

// Request decode plus a two-word queue toward the lookup engine.
module lkv_front import lkv_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lkv_in_if.sink      i_req,
    output logic        o_item_valid,
    output t_item       o_item,
    input  wire logic   i_item_ready
);

    localparam int QDEPTH = 2;

    t_item      r_mem [QDEPTH];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    logic       push;
    logic       pop;
    t_item      in_item;

    assign i_req.ready  = (r_count != 2'(QDEPTH));
    assign push         = i_req.valid && i_req.ready;
    assign o_item_valid = (r_count != 2'd0);
    assign pop          = o_item_valid && i_item_ready;
    assign o_item       = r_mem[r_rptr];

    always_comb begin
        in_item.is_put = (i_req.kind == KIND_PUT);
        in_item.key    = i_req.lookup_key;
        in_item.value  = i_req.put_value;
    end

    always_comb begin
        n_wptr  = push ? ~r_wptr : r_wptr;
        n_rptr  = pop  ? ~r_rptr : r_rptr;
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lkv_back.sv =====
`default_nettype none

// Lookup engine: compare cycle, then update cycle into the output register.
module lkv_back import lkv_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_item_valid,
    input  wire t_item            i_item,
    output logic                  o_item_ready,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    lkv_out_if.source             o_rsp
);

    localparam logic ST_LOOK  = 1'b0;
    localparam logic ST_APPLY = 1'b1;

    // store
    logic signed [KEY_W-1:0] r_keys [ENTRIES];
    logic signed [VAL_W-1:0] r_vals [ENTRIES];
    logic [IDX_W-1:0]        r_rank [ENTRIES];
    logic [IDX_W-1:0]        n_rank [ENTRIES];
    logic [CNT_W-1:0]        r_used, n_used;
    logic [CFG_W-1:0]        r_cap;

    logic                    r_state, n_state;

    // compare results held for the update cycle
    t_item                   r_item;
    logic                    r_hit;
    logic                    r_fill;
    logic [IDX_W-1:0]        r_found;
    logic [IDX_W-1:0]        r_victim;
    logic [IDX_W-1:0]        r_hit_rank;

    // output register
    logic                    r_out_valid;
    t_rsp                    r_out;

    // compare-cycle logic
    logic [ENTRIES-1:0]      match;
    logic                    lk_hit;
    logic [IDX_W-1:0]        lk_found;
    logic [IDX_W-1:0]        lk_victim;
    logic [IDX_W-1:0]        lk_hit_rank;
    logic [CNT_W-1:0]        eff_cap;
    logic [CNT_W-1:0]        oldest;

    // update-cycle logic
    logic                    out_free;
    logic                    do_apply;
    logic                    take;
    logic [IDX_W-1:0]        slot;
    logic [CNT_W-1:0]        old_rank;
    t_rsp                    rsp;

    assign o_item_ready = (r_state == ST_LOOK);
    assign take         = i_item_valid && o_item_ready;
    assign out_free     = !r_out_valid || o_rsp.ready;
    assign do_apply     = (r_state == ST_APPLY) && out_free;

    // capacity zero reads as one, above the depth saturates
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(r_cap) > ENTRIES) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(r_cap);
        end
    end

    // least recent slot in use carries rank used-1 (ranks are a permutation)
    assign oldest = r_used - CNT_W'(1);

    always_comb begin
        lk_found    = '0;
        lk_victim   = '0;
        lk_hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (CNT_W'(i) < r_used) && (r_keys[i] == i_item.key);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                lk_found = IDX_W'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if ((CNT_W'(i) < r_used) && (CNT_W'(r_rank[i]) == oldest)) begin
                lk_victim = IDX_W'(i);
            end
            if (match[i]) begin
                lk_hit_rank = lk_hit_rank | r_rank[i];
            end
        end
        lk_hit = |match;
    end

    // slot touched by the update and its rank before promotion
    always_comb begin
        if (r_hit) begin
            slot     = r_found;
            old_rank = CNT_W'(r_hit_rank);
        end else if (r_fill) begin
            slot     = IDX_W'(r_used);
            old_rank = r_used;
        end else begin
            slot     = r_victim;
            old_rank = oldest;
        end
        n_used = (r_item.is_put && !r_hit && r_fill) ? r_used + CNT_W'(1) : r_used;

        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (IDX_W'(i) == slot) begin
                n_rank[i] = '0;
            end else if ((CNT_W'(i) < n_used) && (CNT_W'(r_rank[i]) < old_rank)) begin
                n_rank[i] = r_rank[i] + IDX_W'(1);
            end
        end

        rsp.hit        = r_hit;
        rsp.read_value = (!r_item.is_put && r_hit) ? r_vals[r_found] : '0;
        rsp.evicted    = r_item.is_put && !r_hit && !r_fill;
    end

    // a get that misses leaves the store and the ranks unchanged
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOOK: begin
                if (take) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    n_state = ST_LOOK;
                end
            end
            default: n_state = ST_LOOK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOOK;
            r_used      <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (do_apply) begin
                r_out_valid <= 1'b1;
                if (r_item.is_put || r_hit) begin
                    r_used <= n_used;
                    for (int i = 0; i < ENTRIES; i++) begin
                        r_rank[i] <= n_rank[i];
                    end
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item     <= i_item;
            r_hit      <= lk_hit;
            r_fill     <= !lk_hit && (r_used < eff_cap);
            r_found    <= lk_found;
            r_victim   <= lk_victim;
            r_hit_rank <= lk_hit_rank;
        end
        if (do_apply) begin
            r_out <= rsp;
            if (r_item.is_put) begin
                r_vals[slot] <= r_item.value;
                if (!r_hit) begin
                    r_keys[slot] <= r_item.key;
                end
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out.hit;
    assign o_rsp.read_value = r_out.read_value;
    assign o_rsp.evicted    = r_out.evicted;

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// LRU key/value cache, fully associative, 16 slots.
// i_req (valid/ready): one word per operation: kind (0 get, 1 put),
//   lookup_key, put_value. Accepted when valid and ready are both high.
// o_rsp (valid/ready): one word per operation, in order: hit, read_value
//   (stored value on a get hit, else zero), evicted (put replaced the
//   least recent slot).
// i_cfg_we/i_cfg_wdata: capacity_in_use; the user must write it only while
//   idle, as the block does not enforce it; zero acts as one, values above
//   the depth act as the depth.
// A word passes the queue, the compare registers and the output register.
// The lookup engine takes one word at a time: a compare step over all slots,
//   then an update step for values and recency ranks, before the next word.
// A two-word queue in front of the engine keeps taking requests while the
//   engine is busy. If the receiver stalls, the result stays in the output
//   register, the engine holds its next result, and the queue fills until
//   ready drops.
// Reset (synchronous, active low) empties the cache, clears the queue and
//   output, and sets the capacity to 16. Slot contents are not cleared.
`default_nettype none

module lru_key_value_cache_unit import lkv_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    lkv_in_if.sink                i_req,
    lkv_out_if.source             o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    // front to engine
    logic  item_valid;
    logic  item_ready;
    t_item item;

    lkv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_ready (item_ready)
    );

    lkv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_ready (item_ready),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_rsp        (o_rsp)
    );

endmodule

`default_nettype wire
